FILE: hdl/bums_pkg.sv
// shared types and state codes for the bottom-up merge sorter
`timescale 1ns / 1ps
package bums_pkg;
   localparam int VALUE_W = 8;
   typedef logic [VALUE_W-1:0] value_type;

   localparam int STATE_W = 3;
   typedef logic [STATE_W-1:0] state_type;

   localparam state_type ST_LOAD  = 3'd0;
   localparam state_type ST_PASS  = 3'd1;
   localparam state_type ST_SEG   = 3'd2;
   localparam state_type ST_MRD   = 3'd3;
   localparam state_type ST_MWR   = 3'd4;
   localparam state_type ST_ERD   = 3'd5;
   localparam state_type ST_EPUT  = 3'd6;
   localparam state_type ST_EWAIT = 3'd7;
endpackage

FILE: hdl/bums_ram.sv
// generic ram, one write port and two registered read ports
`timescale 1ns / 1ps
module bums_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a_ff <= mem[rd_addr_a];
      rd_data_b_ff <= mem[rd_addr_b];
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;
endmodule

FILE: hdl/bums_emit.sv
// output register stage for the sorted result beats
`timescale 1ns / 1ps
module bums_emit (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  bums_pkg::value_type load_value,
   input  logic               load_final,
   output logic               busy,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output bums_pkg::value_type rsp_sorted_value,
   output logic               rsp_final_res
);
   import bums_pkg::*;

   logic      valid_ff;
   value_type value_ff;
   logic      final_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         value_ff <= load_value;
         final_ff <= load_final;
      end
   end

   assign busy             = valid_ff;
   assign rsp_valid        = valid_ff;
   assign rsp_sorted_value = value_ff;
   assign rsp_final_res    = final_ff;
endmodule

FILE: hdl/bottom_up_merge_sorter.sv
// bottom-up merge sorter: load, ping-pong merge passes between two rams, emit
// load: one beat per cycle; a set of n values ends with the beat flagged last
// sort: ceil(log2 n) passes; per element: ram read, then compare and write,
//   with ST_PASS per pass, ST_SEG per run pair or lone run; a final ST_PASS starts emit
// emit: ST_ERD, ST_EPUT, ST_EWAIT per beat, held by rsp_stall; no new set taken till done
// reset: synchronous, active high; clears counters and control, ram contents stay undefined
`timescale 1ns / 1ps
module bottom_up_merge_sorter #(
   parameter int MAX_ELEMENTS = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  bums_pkg::value_type req_value,
   input  logic                req_last,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output bums_pkg::value_type rsp_sorted_value,
   output logic                rsp_final_res
);
   import bums_pkg::*;

   localparam int ADDR_W = $clog2(MAX_ELEMENTS);
   localparam int CNT_W  = $clog2(MAX_ELEMENTS + 1);
   localparam int WID_W  = CNT_W + 1;
   localparam int SUM_W  = CNT_W + 2;

   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [WID_W-1:0]      width_ff, width_in;
   logic [CNT_W-1:0]      base_ff, base_in;
   logic [CNT_W-1:0]      mid_ff, mid_in;
   logic [CNT_W-1:0]      end_ff, end_in;
   logic [CNT_W-1:0]      left_ff, left_in;
   logic [CNT_W-1:0]      right_ff, right_in;
   logic [CNT_W-1:0]      wp_ff, wp_in;
   logic                  src_ff, src_in;

   logic                  req_accept;
   logic                  load_wr;
   logic [SUM_W-1:0]      n_ext;
   logic [SUM_W-1:0]      mid_sum;
   logic [SUM_W-1:0]      end_sum;
   logic [SUM_W-1:0]      next_base;
   logic [CNT_W-1:0]      wp_next;
   logic                  take_left;
   value_type             merge_value;

   logic [ADDR_W-1:0]     rd_addr_a;
   logic [ADDR_W-1:0]     rd_addr_b;
   logic                  a_wr_en;
   logic [ADDR_W-1:0]     a_wr_addr;
   value_type             a_wr_data;
   value_type             a_rd_a, a_rd_b;
   logic                  b_wr_en;
   value_type             b_rd_a, b_rd_b;
   value_type             src_rd_a, src_rd_b;

   logic                  emit_load;
   logic                  emit_final;
   logic                  emit_busy;

   assign req_stall  = (state_ff != ST_LOAD);
   assign req_accept = req_valid && !req_stall;
   assign load_wr    = req_accept && (count_ff < CNT_W'(MAX_ELEMENTS));

   assign n_ext     = SUM_W'(count_ff);
   assign mid_sum   = SUM_W'(base_ff) + SUM_W'(width_ff);
   assign end_sum   = SUM_W'(base_ff) + SUM_W'({width_ff, 1'b0});
   assign next_base = SUM_W'(base_ff) + SUM_W'({width_ff, 1'b0});
   assign wp_next   = wp_ff + CNT_W'(1);

   assign src_rd_a = src_ff ? b_rd_a : a_rd_a;
   assign src_rd_b = src_ff ? b_rd_b : a_rd_b;

   always_comb begin
      if (left_ff >= mid_ff) begin
         take_left = 1'b0;
      end else if (right_ff >= end_ff) begin
         take_left = 1'b1;
      end else begin
         take_left = (src_rd_a <= src_rd_b);
      end
   end
   assign merge_value = take_left ? src_rd_a : src_rd_b;

   assign rd_addr_a = (state_ff == ST_ERD) ? wp_ff[ADDR_W-1:0] : left_ff[ADDR_W-1:0];
   assign rd_addr_b = right_ff[ADDR_W-1:0];

   assign a_wr_en   = load_wr || ((state_ff == ST_MWR) && src_ff);
   assign a_wr_addr = (state_ff == ST_LOAD) ? count_ff[ADDR_W-1:0] : wp_ff[ADDR_W-1:0];
   assign a_wr_data = (state_ff == ST_LOAD) ? req_value : merge_value;
   assign b_wr_en   = (state_ff == ST_MWR) && !src_ff;

   assign emit_load  = (state_ff == ST_EPUT);
   assign emit_final = (wp_next == count_ff);

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      width_in = width_ff;
      base_in  = base_ff;
      mid_in   = mid_ff;
      end_in   = end_ff;
      left_in  = left_ff;
      right_in = right_ff;
      wp_in    = wp_ff;
      src_in   = src_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (load_wr) begin
               count_in = count_ff + CNT_W'(1);
            end
            if (req_accept && req_last) begin
               width_in = WID_W'(1);
               src_in   = 1'b0;
               state_in = ST_PASS;
            end
         end
         ST_PASS: begin
            if (width_ff >= WID_W'(count_ff)) begin
               wp_in    = '0;
               state_in = ST_ERD;
            end else begin
               base_in  = '0;
               state_in = ST_SEG;
            end
         end
         ST_SEG: begin
            mid_in   = (mid_sum < n_ext) ? mid_sum[CNT_W-1:0] : count_ff;
            end_in   = (end_sum < n_ext) ? end_sum[CNT_W-1:0] : count_ff;
            left_in  = base_ff;
            right_in = (mid_sum < n_ext) ? mid_sum[CNT_W-1:0] : count_ff;
            wp_in    = base_ff;
            state_in = ST_MRD;
         end
         ST_MRD: begin
            state_in = ST_MWR;
         end
         ST_MWR: begin
            if (take_left) begin
               left_in = left_ff + CNT_W'(1);
            end else begin
               right_in = right_ff + CNT_W'(1);
            end
            wp_in = wp_next;
            if (wp_next == end_ff) begin
               if (next_base >= n_ext) begin
                  width_in = {width_ff[WID_W-2:0], 1'b0};
                  src_in   = !src_ff;
                  state_in = ST_PASS;
               end else begin
                  base_in  = next_base[CNT_W-1:0];
                  state_in = ST_SEG;
               end
            end else begin
               state_in = ST_MRD;
            end
         end
         ST_ERD: begin
            state_in = ST_EPUT;
         end
         ST_EPUT: begin
            wp_in    = wp_next;
            state_in = ST_EWAIT;
         end
         ST_EWAIT: begin
            if (!emit_busy) begin
               if (wp_ff == count_ff) begin
                  count_in = '0;
                  width_in = WID_W'(1);
                  left_in  = '0;
                  right_in = '0;
                  wp_in    = '0;
                  state_in = ST_LOAD;
               end else begin
                  state_in = ST_ERD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         count_ff <= '0;
         width_ff <= WID_W'(1);
         left_ff  <= '0;
         right_ff <= '0;
         wp_ff    <= '0;
         src_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         width_ff <= width_in;
         left_ff  <= left_in;
         right_ff <= right_in;
         wp_ff    <= wp_in;
         src_ff   <= src_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff <= base_in;
      mid_ff  <= mid_in;
      end_ff  <= end_in;
   end

   bums_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (MAX_ELEMENTS)
   ) u_ram_a (
      .clock     (clock),
      .wr_en     (a_wr_en),
      .wr_addr   (a_wr_addr),
      .wr_data   (a_wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_data_a (a_rd_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_b (a_rd_b)
   );

   bums_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (MAX_ELEMENTS)
   ) u_ram_b (
      .clock     (clock),
      .wr_en     (b_wr_en),
      .wr_addr   (wp_ff[ADDR_W-1:0]),
      .wr_data   (merge_value),
      .rd_addr_a (rd_addr_a),
      .rd_data_a (b_rd_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_b (b_rd_b)
   );

   bums_emit u_emit (
      .clock            (clock),
      .reset            (reset),
      .load             (emit_load),
      .load_value       (src_rd_a),
      .load_final       (emit_final),
      .busy             (emit_busy),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_final_res    (rsp_final_res)
   );
endmodule
